// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sampler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sampler assertion failed");
// Check that a condition never occurs outside reset
`define ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("sampler forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== rtl/tbs_pkg.sv =====
// Shared constants and types of the bilinear texture sampler
package tbs_pkg;
	// request opcodes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// register indexes on the configuration port
	localparam logic REG_TEX_WIDTH  = 1'b0;
	localparam logic REG_TEX_HEIGHT = 1'b1;

	// texture size limits and reset value
	localparam logic [8:0] SIZE_MAX = 9'd256;
	localparam logic [8:0] SIZE_MIN = 9'd1;

	// half a texel in Q.16
	localparam logic [24:0] HALF_TEXEL = 25'h0008000;

	// stage enables handed to the blend datapath
	typedef struct packed {
		logic en_s6;
		logic en_s7;
	} blend_ctl_t;
endpackage

// ===== rtl/tbs_texmem.sv =====
// Texel store copy: one write port, two registered read ports
module tbs_texmem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [23:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [23:0]   rdata0,
	output logic [23:0]   rdata1
);
	logic [23:0] mem [DEPTH];

	// write one texel
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read two texels, hold while the stage is stalled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end
endmodule

// ===== rtl/tbs_blend.sv =====
// Two-stage bilinear blend of one color channel
module tbs_blend #(
	parameter int WB = 8
) (
	input  logic                clk,
	input  tbs_pkg::blend_ctl_t ctl,
	input  logic [WB-1:0]       fx,
	input  logic [WB-1:0]       fy,
	input  logic [7:0]          c00,
	input  logic [7:0]          c01,
	input  logic [7:0]          c10,
	input  logic [7:0]          c11,
	output logic [15:0]         res
);
	localparam int HW  = 8 + WB;
	localparam int HW1 = HW + 1;
	localparam int TW  = 8 + 2 * WB;
	localparam int TW1 = TW + 1;
	localparam logic [WB:0] S = (WB + 1)'(1) << WB;

	logic [WB:0]   wx0;
	logic [WB:0]   wy0;
	logic [HW1-1:0] top_n;
	logic [HW1-1:0] bot_n;
	logic [HW-1:0] top_s6;
	logic [HW-1:0] bot_s6;
	logic [WB-1:0] fy_s6;
	logic [TW1-1:0] t_n;

	// horizontal blend of both rows
	assign wx0   = S - {1'b0, fx};
	assign top_n = HW1'(c00) * HW1'(wx0) + HW1'(c01) * HW1'(fx);
	assign bot_n = HW1'(c10) * HW1'(wx0) + HW1'(c11) * HW1'(fx);

	always_ff @(posedge clk) begin
		if (ctl.en_s6) begin
			top_s6 <= top_n[HW-1:0];
			bot_s6 <= bot_n[HW-1:0];
			fy_s6  <= fy;
		end
	end

	// vertical blend, drop the extra fraction bits
	assign wy0 = S - {1'b0, fy_s6};
	assign t_n = TW1'(top_s6) * TW1'(wy0) + TW1'(bot_s6) * TW1'(fy_s6);

	always_ff @(posedge clk) begin
		if (ctl.en_s7) begin
			res <= t_n[TW-1 -: 16];
		end
	end
endmodule

// ===== rtl/bilinear_texture_sampler.sv =====
// Bilinear texture sampler, RGB888 store, edge-clamped 2x2 filter, 8.8 output.
// A sample passes stages 1 to 7 in order and shows on the output from the stage 7 register.
// Throughput: one request per cycle while out_stall is low; the seven stages squeeze out bubbles.
// Four texels are read per cycle, unless stage 5 is stalled, from two store copies of two read ports each.
// Reset clears the valid bits and sets both texture sizes to 256;
// the texel store is not cleared and holds nothing useful until written.
`include "assert_macros.svh"
module bilinear_texture_sampler #(
	parameter int MAX_TEXELS  = 65536,
	parameter int WEIGHT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [15:0] texel_addr,
	input  logic [7:0]  wr_red,
	input  logic [7:0]  wr_green,
	input  logic [7:0]  wr_blue,
	input  logic [15:0] u_coord,
	input  logic [15:0] v_coord,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_red,
	output logic [15:0] out_green,
	output logic [15:0] out_blue,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int WB = WEIGHT_BITS;
	localparam int AW = $clog2(MAX_TEXELS);

	logic [8:0] tex_width_q;
	logic [8:0] tex_height_q;
	logic [8:0] w_eff;
	logic [8:0] h_eff;
	logic [8:0] wm1;
	logic [8:0] hm1;

	logic en1, en2, en3, en4, en5, en6, en7;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic        op_s1, op_s2, op_s3, op_s4;
	logic [15:0] addr_s1, addr_s2, addr_s3, addr_s4;
	logic [23:0] rgb_s1, rgb_s2, rgb_s3, rgb_s4;
	logic [15:0] uc_s1, vc_s1;
	logic [24:0] pu_s2, pv_s2;
	logic [7:0]  x0_s3, x1_s3, y0_s3, y1_s3;
	logic [WB-1:0] fx_s3, fy_s3, fx_s4, fy_s4, fx_s5, fy_s5;
	logic [7:0]  x0_s4, x1_s4;
	logic [16:0] rb0_s4, rb1_s4;
	logic        oor00_s5, oor01_s5, oor10_s5, oor11_s5;

	logic [8:0]  ix1, ix0, iy1, iy0;
	logic [16:0] a00, a01, a10, a11;
	logic [31:0] a00_x, a01_x, a10_x, a11_x, wa_x;
	logic        mem_we;
	logic [23:0] t00, t01, t10, t11;
	logic [23:0] m00, m01, m10, m11;
	tbs_pkg::blend_ctl_t bctl;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= tbs_pkg::SIZE_MAX;
			tex_height_q <= tbs_pkg::SIZE_MAX;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				tbs_pkg::REG_TEX_WIDTH:  tex_width_q  <= pwdata[8:0];
				tbs_pkg::REG_TEX_HEIGHT: tex_height_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			tbs_pkg::REG_TEX_WIDTH:  prdata = {23'd0, tex_width_q};
			tbs_pkg::REG_TEX_HEIGHT: prdata = {23'd0, tex_height_q};
			default:                 prdata = 32'd0;
		endcase
	end
	assign pready = 1'b1;

	// clamp sizes into 1..256
	assign w_eff = (tex_width_q == 9'd0) ? tbs_pkg::SIZE_MIN :
		(tex_width_q > tbs_pkg::SIZE_MAX) ? tbs_pkg::SIZE_MAX : tex_width_q;
	assign h_eff = (tex_height_q == 9'd0) ? tbs_pkg::SIZE_MIN :
		(tex_height_q > tbs_pkg::SIZE_MAX) ? tbs_pkg::SIZE_MAX : tex_height_q;
	assign wm1 = w_eff - 9'd1;
	assign hm1 = h_eff - 9'd1;

	// stage enables: load when empty or when the stage below moves on
	assign en7 = !vld_s7 || !out_stall;
	assign en6 = !vld_s6 || en7;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign in_stall = !en1;

	// advance the valid bits; writes leave after the store stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4 && (op_s4 == tbs_pkg::OP_SAMPLE);
			if (en6) vld_s6 <= vld_s5;
			if (en7) vld_s7 <= vld_s6;
		end
	end

	// stage 1: capture the request
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1   <= op;
			addr_s1 <= texel_addr;
			rgb_s1  <= {wr_red, wr_green, wr_blue};
			uc_s1   <= u_coord;
			vc_s1   <= v_coord;
		end
	end

	// stage 2: scale coordinates and offset by half a texel
	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2   <= op_s1;
			addr_s2 <= addr_s1;
			rgb_s2  <= rgb_s1;
			pu_s2   <= 25'(uc_s1) * 25'(w_eff) + tbs_pkg::HALF_TEXEL;
			pv_s2   <= 25'(vc_s1) * 25'(h_eff) + tbs_pkg::HALF_TEXEL;
		end
	end

	// stage 3: neighbor indices clamped to the edge, weights
	assign ix1 = pu_s2[24:16];
	assign ix0 = (ix1 == 9'd0) ? 9'd0 : ix1 - 9'd1;
	assign iy1 = pv_s2[24:16];
	assign iy0 = (iy1 == 9'd0) ? 9'd0 : iy1 - 9'd1;

	always_ff @(posedge clk) begin
		if (en3) begin
			op_s3   <= op_s2;
			addr_s3 <= addr_s2;
			rgb_s3  <= rgb_s2;
			x0_s3   <= (ix0 > wm1) ? wm1[7:0] : ix0[7:0];
			x1_s3   <= (ix1 > wm1) ? wm1[7:0] : ix1[7:0];
			y0_s3   <= (iy0 > hm1) ? hm1[7:0] : iy0[7:0];
			y1_s3   <= (iy1 > hm1) ? hm1[7:0] : iy1[7:0];
			fx_s3   <= pu_s2[15 -: WB];
			fy_s3   <= pv_s2[15 -: WB];
		end
	end

	// stage 4: row base addresses
	always_ff @(posedge clk) begin
		if (en4) begin
			op_s4   <= op_s3;
			addr_s4 <= addr_s3;
			rgb_s4  <= rgb_s3;
			rb0_s4  <= 17'(y0_s3) * 17'(w_eff);
			rb1_s4  <= 17'(y1_s3) * 17'(w_eff);
			x0_s4   <= x0_s3;
			x1_s4   <= x1_s3;
			fx_s4   <= fx_s3;
			fy_s4   <= fy_s3;
		end
	end

	// texel addresses and store write, in request order
	assign a00 = rb0_s4 + 17'(x0_s4);
	assign a01 = rb0_s4 + 17'(x1_s4);
	assign a10 = rb1_s4 + 17'(x0_s4);
	assign a11 = rb1_s4 + 17'(x1_s4);
	assign a00_x = 32'(a00);
	assign a01_x = 32'(a01);
	assign a10_x = 32'(a10);
	assign a11_x = 32'(a11);
	assign wa_x  = 32'(addr_s4);
	assign mem_we = en5 && vld_s4 && (op_s4 == tbs_pkg::OP_WRITE) &&
		(wa_x < 32'(MAX_TEXELS));

	tbs_texmem #(.DEPTH(MAX_TEXELS), .AW(AW)) u_mem_row0 (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (wa_x[AW-1:0]),
		.wdata  (rgb_s4),
		.re     (en5),
		.raddr0 (a00_x[AW-1:0]),
		.raddr1 (a01_x[AW-1:0]),
		.rdata0 (t00),
		.rdata1 (t01)
	);

	tbs_texmem #(.DEPTH(MAX_TEXELS), .AW(AW)) u_mem_row1 (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (wa_x[AW-1:0]),
		.wdata  (rgb_s4),
		.re     (en5),
		.raddr0 (a10_x[AW-1:0]),
		.raddr1 (a11_x[AW-1:0]),
		.rdata0 (t10),
		.rdata1 (t11)
	);

	// stage 5: texel data arrives; mark neighbors beyond the store
	always_ff @(posedge clk) begin
		if (en5) begin
			oor00_s5 <= a00_x >= 32'(MAX_TEXELS);
			oor01_s5 <= a01_x >= 32'(MAX_TEXELS);
			oor10_s5 <= a10_x >= 32'(MAX_TEXELS);
			oor11_s5 <= a11_x >= 32'(MAX_TEXELS);
			fx_s5    <= fx_s4;
			fy_s5    <= fy_s4;
		end
	end

	// read neighbors beyond the store as black
	assign m00 = oor00_s5 ? 24'd0 : t00;
	assign m01 = oor01_s5 ? 24'd0 : t01;
	assign m10 = oor10_s5 ? 24'd0 : t10;
	assign m11 = oor11_s5 ? 24'd0 : t11;

	assign bctl.en_s6 = en6;
	assign bctl.en_s7 = en7;

	// stages 6 and 7: blend each channel
	tbs_blend #(.WB(WB)) u_blend_red (
		.clk (clk), .ctl (bctl), .fx (fx_s5), .fy (fy_s5),
		.c00 (m00[23:16]), .c01 (m01[23:16]), .c10 (m10[23:16]), .c11 (m11[23:16]),
		.res (out_red)
	);

	tbs_blend #(.WB(WB)) u_blend_green (
		.clk (clk), .ctl (bctl), .fx (fx_s5), .fy (fy_s5),
		.c00 (m00[15:8]), .c01 (m01[15:8]), .c10 (m10[15:8]), .c11 (m11[15:8]),
		.res (out_green)
	);

	tbs_blend #(.WB(WB)) u_blend_blue (
		.clk (clk), .ctl (bctl), .fx (fx_s5), .fy (fy_s5),
		.c00 (m00[7:0]), .c01 (m01[7:0]), .c10 (m10[7:0]), .c11 (m11[7:0]),
		.res (out_blue)
	);

	assign out_valid = vld_s7;

	// checks
	`ASSERT_CLK(a_stall_needs_full, in_stall |-> vld_s1)
	`ASSERT_NEVER(a_no_write_on_sample, mem_we && (op_s4 == tbs_pkg::OP_SAMPLE))
	`ASSERT_CLK(a_x_order, (vld_s3 && (op_s3 == tbs_pkg::OP_SAMPLE)) |-> (x0_s3 <= x1_s3))
	`ASSERT_CLK(a_s6_held, (vld_s6 && !en6) |=> vld_s6)
endmodule
